// ----- design/positional_list_table_core_assert.svh -----
// assertion macros for the positional list table
`ifndef POSITIONAL_LIST_TABLE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PLT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional list table assertion failed");
`define PLT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional list table assertion failed");
`else
`define PLT_ASSERT_IMP(label, clk, rst, ante, cons)
`define PLT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- design/plt_pkg.sv -----
// shared types and codes of the positional list table
`timescale 1ns / 1ps

package plt_pkg;

   typedef logic signed [31:0] word_type;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic       load;
      logic       shift_rd;
      logic       shift_wr;
      logic       put_word;
      logic       rd_entry;
      logic       finish;
      logic       take_data;
      logic       len_inc;
      logic       len_dec;
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       ins_ok;
      logic       acc_ok;
      logic       full;
      logic       more;
      logic       slot_free;
   } stat_type;

endpackage

// ----- design/plt_channels.sv -----
// request and response channel interfaces of the positional list table
`timescale 1ns / 1ps

interface plt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [7:0]         position;
   plt_pkg::word_type  value;

   modport source(output valid, output req_type, output position, output value,
                  input ready);
   modport sink(input valid, input req_type, input position, input value,
                output ready);
endinterface

interface plt_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   plt_pkg::word_type  read_data;
   logic [6:0]         list_length;

   modport source(output valid, output status, output read_data, output list_length,
                  input ready);
   modport sink(input valid, input status, input read_data, input list_length,
                output ready);
endinterface

// ----- design/positional_list_table_core.sv -----
// top level of the positional list table
// req_chan takes one word per request: req_type (insert, delete, read),
// a one-based position and the value to insert. rsp_chan returns one word
// per request: status, read_data (zero unless a read succeeds) and the
// list length after the request.
// requests are handled one at a time; req_chan.ready is high only while
// the sequencer is idle.
// a request runs through the sequencer states in order: S_IDLE loads it,
// S_CHECK tests it (a read fetches its entry there), each moved entry
// takes S_RD and S_WR and returns to S_CHECK, an insert writes its word
// in S_PUT, and S_DONE loads the response.
// every moved entry costs a memory read, a memory write and a cursor check
// on the list memory, so the worst case grows with CAPACITY.
// the sequencer returns to S_IDLE as a response is loaded and takes the
// next request from there.
// the response sits in an output register; the next request is taken while
// it waits, and a finished request holds in the sequencer until the
// receiver has taken the previous response.
// reset empties the list (length zero) and drops any pending response;
// the list memory itself is not cleared.
`timescale 1ns / 1ps

module positional_list_table_core #(
   parameter int CAPACITY = 64
) (
   input logic     clock,
   input logic     reset,
   plt_req_if.sink req_chan,
   plt_rsp_if.source rsp_chan
);

   plt_pkg::cmd_type  cmd;
   plt_pkg::stat_type stat;
   logic              ready;

   assign req_chan.ready = ready;

   plt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   plt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_type     (req_chan.req_type),
      .req_position (req_chan.position),
      .req_value    (req_chan.value),
      .rsp          (rsp_chan)
   );

endmodule

// ----- design/plt_datapath.sv -----
// list memory, length, cursor and response register of the positional list table
`timescale 1ns / 1ps
`include "positional_list_table_core_assert.svh"

module plt_datapath #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  plt_pkg::cmd_type  cmd,
   output plt_pkg::stat_type stat,
   input  logic [1:0]        req_type,
   input  logic [7:0]        req_position,
   input  plt_pkg::word_type req_value,
   plt_rsp_if.source         rsp
);

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = ((LW > 8) ? LW : 8) + 1;

   plt_pkg::word_type mem [CAPACITY];
   plt_pkg::word_type rd_data_ff;

   logic [LW-1:0]     length_ff;
   logic [LW-1:0]     length_in;
   logic [LW-1:0]     idx_ff;
   logic [1:0]        kind_ff;
   logic [7:0]        pos_ff;
   plt_pkg::word_type word_ff;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   plt_pkg::word_type rsp_data_ff;
   logic [6:0]        rsp_len_ff;

   logic [CW-1:0]     pos_w;
   logic [CW-1:0]     len_w;
   logic [CW-1:0]     idx_w;
   logic [CW-1:0]     req_pos_w;
   logic [LW+6:0]     len_wide;

   logic              mem_we;
   logic [AW-1:0]     wr_addr;
   plt_pkg::word_type wr_data;
   logic              mem_re;
   logic [AW-1:0]     rd_addr;

   assign pos_w     = CW'(pos_ff);
   assign len_w     = CW'(length_ff);
   assign idx_w     = CW'(idx_ff);
   assign req_pos_w = CW'(req_position);

   always_comb begin
      stat.kind      = kind_ff;
      stat.ins_ok    = (pos_ff != 8'd0) && (pos_w <= len_w + CW'(1));
      stat.acc_ok    = (pos_ff != 8'd0) && (pos_w <= len_w);
      stat.full      = (length_ff == LW'(CAPACITY));
      stat.slot_free = !rsp_valid_ff || rsp.ready;
      if (kind_ff == plt_pkg::REQ_INSERT) begin
         stat.more = (pos_ff != 8'd0) && (idx_w >= pos_w);
      end else begin
         stat.more = (idx_w + CW'(1)) < len_w;
      end
   end

   always_comb begin
      mem_we  = cmd.shift_wr || cmd.put_word;
      wr_addr = cmd.put_word ? AW'(pos_w - CW'(1)) : idx_ff[AW-1:0];
      wr_data = cmd.put_word ? word_ff : rd_data_ff;
      mem_re  = cmd.shift_rd || cmd.rd_entry;
      if (cmd.rd_entry) begin
         rd_addr = AW'(pos_w - CW'(1));
      end else if (kind_ff == plt_pkg::REQ_INSERT) begin
         rd_addr = AW'(idx_ff - LW'(1));
      end else begin
         rd_addr = AW'(idx_ff + LW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      length_in = length_ff;
      if (cmd.finish && cmd.len_inc) begin
         length_in = length_ff + LW'(1);
      end else if (cmd.finish && cmd.len_dec) begin
         length_in = length_ff - LW'(1);
      end
   end

   assign len_wide = {7'd0, length_in};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_type;
         pos_ff  <= req_position;
         word_ff <= req_value;
         if (req_type == plt_pkg::REQ_INSERT) begin
            idx_ff <= length_ff;
         end else begin
            idx_ff <= LW'(req_pos_w - CW'(1));
         end
      end else if (cmd.shift_wr) begin
         if (kind_ff == plt_pkg::REQ_INSERT) begin
            idx_ff <= idx_ff - LW'(1);
         end else begin
            idx_ff <= idx_ff + LW'(1);
         end
      end
      if (cmd.finish) begin
         rsp_status_ff <= cmd.status;
         rsp_data_ff   <= cmd.take_data ? rd_data_ff : '0;
         rsp_len_ff    <= len_wide[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff <= length_in;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.read_data   = rsp_data_ff;
   assign rsp.list_length = rsp_len_ff;

   `PLT_ASSERT_IMP(a_len_cap, clock, reset, 1'b1, length_ff <= LW'(CAPACITY))
   `PLT_ASSERT_IMP(a_finish_slot, clock, reset, cmd.finish, !rsp_valid_ff || rsp.ready)
   `PLT_ASSERT_IMP(a_inc_room, clock, reset, cmd.finish && cmd.len_inc, !stat.full)
   `PLT_ASSERT_IMP(a_data_ok, clock, reset, cmd.finish && cmd.take_data,
                   cmd.status == plt_pkg::ST_OK)
   `PLT_ASSERT_NXT(a_finish_valid, clock, reset, cmd.finish, rsp_valid_ff)

endmodule

// ----- design/plt_controller.sv -----
// sequencing state machine of the positional list table
`timescale 1ns / 1ps

module plt_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  plt_pkg::stat_type stat,
   output plt_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_RD,
      S_WR,
      S_PUT,
      S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       inc_ff, inc_in;
   logic       dec_ff, dec_in;
   logic       take_ff, take_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      inc_in    = inc_ff;
      dec_in    = dec_ff;
      take_in   = take_ff;
      cmd       = '0;
      cmd.status    = status_ff;
      cmd.take_data = take_ff;
      cmd.len_inc   = inc_ff;
      cmd.len_dec   = dec_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               inc_in   = 1'b0;
               dec_in   = 1'b0;
               take_in  = 1'b0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            unique case (stat.kind)
               plt_pkg::REQ_INSERT: begin
                  if (!stat.ins_ok) begin
                     status_in = plt_pkg::ST_RANGE;
                     state_in  = S_DONE;
                  end else if (stat.full) begin
                     status_in = plt_pkg::ST_FULL;
                     state_in  = S_DONE;
                  end else if (stat.more) begin
                     state_in = S_RD;
                  end else begin
                     state_in = S_PUT;
                  end
               end
               plt_pkg::REQ_DELETE: begin
                  if (!stat.acc_ok) begin
                     status_in = plt_pkg::ST_RANGE;
                     state_in  = S_DONE;
                  end else if (stat.more) begin
                     state_in = S_RD;
                  end else begin
                     status_in = plt_pkg::ST_OK;
                     dec_in    = 1'b1;
                     state_in  = S_DONE;
                  end
               end
               plt_pkg::REQ_READ: begin
                  if (!stat.acc_ok) begin
                     status_in = plt_pkg::ST_RANGE;
                  end else begin
                     cmd.rd_entry = 1'b1;
                     status_in    = plt_pkg::ST_OK;
                     take_in      = 1'b1;
                  end
                  state_in = S_DONE;
               end
               default: begin
                  status_in = plt_pkg::ST_RANGE;
                  state_in  = S_DONE;
               end
            endcase
         end
         S_RD: begin
            cmd.shift_rd = 1'b1;
            state_in     = S_WR;
         end
         S_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_CHECK;
         end
         S_PUT: begin
            cmd.put_word = 1'b1;
            status_in    = plt_pkg::ST_OK;
            inc_in       = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (stat.slot_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= plt_pkg::ST_OK;
         inc_ff    <= 1'b0;
         dec_ff    <= 1'b0;
         take_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         inc_ff    <= inc_in;
         dec_ff    <= dec_in;
         take_ff   <= take_in;
      end
   end

endmodule
